// ----- hw/rtl/cpuexc_pkg.sv -----
package cpuexc_pkg;

    localparam logic [31:0] VEC_ROM     = 32'hBFC0_0180;
    localparam logic [31:0] VEC_RAM     = 32'h8000_0080;
    localparam logic [31:0] START_RESET = 32'hBFC0_0000;
    localparam logic [31:0] INSTR_BYTES = 32'd4;
    localparam logic [5:0]  MODE_MASK   = 6'h3F;

    // configuration register indexes
    localparam logic CFG_BEV   = 1'b0;
    localparam logic CFG_START = 1'b1;

    typedef enum logic [2:0] {
        CMD_PLAIN  = 3'd0,
        CMD_BRANCH = 3'd1,
        CMD_LOAD   = 3'd2,
        CMD_EXC    = 3'd3,
        CMD_RFE    = 3'd4
    } cmd_t;

    typedef struct packed {
        logic [31:0] fetch_addr;
        logic        exc_taken;
        logic [31:0] epc_value;
        logic [31:0] cause_value;
        logic [5:0]  mode_bits;
        logic        wb_en;
        logic [4:0]  wb_reg;
        logic [31:0] wb_value;
        logic [31:0] pc_after;
    } res_t;

endpackage

// ----- hw/rtl/cpu_exception_and_delay_slot_control.sv -----
// an accepted request's result is registered into the result register, or into the skid entry
// throughput: one request per cycle unless in_stall; sequencer loops through one register stage
// a two-entry output buffer (result register plus skid) lets input run while output waits
// in_stall rises only when both output entries hold results
// reset (async, rst_n low): pc/instr_pc 0xBFC00000, next_pc +4, BEV 1, rest 0 except result data
module cpu_exception_and_delay_slot_control
    import cpuexc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  cmd,
    input  logic        irq,
    input  logic [31:0] target,
    input  logic [4:0]  load_dest,
    input  logic [31:0] load_data,
    input  logic [4:0]  exc_code,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] fetch_addr,
    output logic        exc_taken,
    output logic [31:0] epc_value,
    output logic [31:0] cause_value,
    output logic [5:0]  mode_bits,
    output logic        wb_en,
    output logic [4:0]  wb_reg,
    output logic [31:0] wb_value,
    output logic [31:0] pc_after,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    logic        bev_reg;
    logic [31:0] pc_reg;
    logic [31:0] next_pc_reg;
    logic [31:0] instr_pc_reg;
    logic        armed_reg;
    logic [31:0] btarget_reg;
    logic [4:0]  retire_reg;
    logic [31:0] retire_value_reg;
    logic [5:0]  mode_reg;
    logic [31:0] epc_reg;
    logic [31:0] cause_reg;

    res_t        out_reg;
    logic        out_valid_reg;
    res_t        skid_reg;
    logic        skid_valid_reg;

    logic        accept;
    logic        pop;
    logic        cfg_wr;
    logic [31:0] vec_addr;
    logic        slot;
    logic        redirect;
    logic [4:0]  ld_reg;

    logic [31:0] pc_next;
    logic [31:0] next_pc_next;
    logic [5:0]  mode_next;
    logic [31:0] epc_next;
    logic [31:0] cause_next;
    logic [31:0] fetch_v;
    logic        wb_v;
    res_t        res_next;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid & cfg_ready;
    assign in_stall  = skid_valid_reg;
    assign accept    = in_valid & ~skid_valid_reg;
    assign pop       = out_valid_reg & ~out_stall;
    assign vec_addr  = bev_reg ? VEC_ROM : VEC_RAM;

    // an armed branch puts this request in its delay slot unless an interrupt cancels it
    assign slot     = armed_reg & ~irq;
    assign redirect = slot & (cmd != CMD_BRANCH) & (cmd != CMD_EXC);
    assign ld_reg   = (cmd == CMD_LOAD) ? load_dest : 5'd0;
    // a retiring load is dropped when this request's load targets the same register
    assign wb_v     = (ld_reg != retire_reg) && (retire_reg != 5'd0);

    always_comb
    begin
        mode_next    = mode_reg;
        epc_next     = epc_reg;
        cause_next   = cause_reg;
        pc_next      = pc_reg;
        next_pc_next = next_pc_reg;

        // interrupt taken ahead of the fetch
        if (irq)
        begin
            mode_next    = {mode_next[3:0], 2'b00} & MODE_MASK;
            epc_next     = armed_reg ? (pc_reg - INSTR_BYTES) : pc_reg;
            cause_next   = {armed_reg, 31'd0};
            pc_next      = vec_addr;
            next_pc_next = vec_addr + INSTR_BYTES;
        end

        fetch_v      = pc_next;
        pc_next      = next_pc_next;
        next_pc_next = next_pc_next + INSTR_BYTES;

        unique case (cmd)
            CMD_EXC:
            begin
                mode_next    = {mode_next[3:0], 2'b00} & MODE_MASK;
                epc_next     = slot ? (instr_pc_reg - INSTR_BYTES) : instr_pc_reg;
                cause_next   = {slot, 24'd0, exc_code, 2'b00};
                pc_next      = vec_addr;
                next_pc_next = vec_addr + INSTR_BYTES;
            end
            CMD_RFE:
            begin
                mode_next = {mode_next[5:4], mode_next[5:2]};
            end
            default:
            begin
                mode_next = mode_next;
            end
        endcase

        if (redirect)
        begin
            pc_next      = btarget_reg;
            next_pc_next = btarget_reg + INSTR_BYTES;
        end

        res_next.fetch_addr  = fetch_v;
        res_next.exc_taken   = irq | (cmd == CMD_EXC);
        res_next.epc_value   = epc_next;
        res_next.cause_value = cause_next;
        res_next.mode_bits   = mode_next;
        res_next.wb_en       = wb_v;
        res_next.wb_reg      = wb_v ? retire_reg : 5'd0;
        res_next.wb_value    = wb_v ? retire_value_reg : 32'd0;
        res_next.pc_after    = pc_next;
    end

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bev_reg          <= 1'b1;
            pc_reg           <= START_RESET;
            next_pc_reg      <= START_RESET + INSTR_BYTES;
            instr_pc_reg     <= START_RESET;
            armed_reg        <= 1'b0;
            btarget_reg      <= 32'd0;
            retire_reg       <= 5'd0;
            retire_value_reg <= 32'd0;
            mode_reg         <= 6'd0;
            epc_reg          <= 32'd0;
            cause_reg        <= 32'd0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                CFG_BEV:
                begin
                    bev_reg <= cfg_data[0];
                end
                CFG_START:
                begin
                    pc_reg       <= cfg_data;
                    next_pc_reg  <= cfg_data + INSTR_BYTES;
                    instr_pc_reg <= cfg_data;
                end
            endcase
        end
        else if (accept)
        begin
            pc_reg       <= pc_next;
            next_pc_reg  <= next_pc_next;
            instr_pc_reg <= pc_next;
            armed_reg    <= (cmd == CMD_BRANCH);
            if (cmd == CMD_BRANCH)
            begin
                btarget_reg <= target;
            end
            retire_reg <= ld_reg;
            if (cmd == CMD_LOAD)
            begin
                retire_value_reg <= load_data;
            end
            mode_reg  <= mode_next;
            epc_reg   <= epc_next;
            cause_reg <= cause_next;
        end
    end

    // result register and skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (skid_valid_reg)
            begin
                if (pop)
                begin
                    out_reg        <= skid_reg;
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (accept)
            begin
                if (out_valid_reg && !pop)
                begin
                    skid_reg       <= res_next;
                    skid_valid_reg <= 1'b1;
                end
                else
                begin
                    out_reg       <= res_next;
                    out_valid_reg <= 1'b1;
                end
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign fetch_addr  = out_reg.fetch_addr;
    assign exc_taken   = out_reg.exc_taken;
    assign epc_value   = out_reg.epc_value;
    assign cause_value = out_reg.cause_value;
    assign mode_bits   = out_reg.mode_bits;
    assign wb_en       = out_reg.wb_en;
    assign wb_reg      = out_reg.wb_reg;
    assign wb_value    = out_reg.wb_value;
    assign pc_after    = out_reg.pc_after;

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while result register empty");

    a_wb_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.wb_en) |-> (out_reg.wb_reg != 5'd0))
        else $error("write-back to register zero");

    a_no_wb_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.wb_en) |->
            (out_reg.wb_reg == 5'd0 && out_reg.wb_value == 32'd0))
        else $error("write-back fields not cleared");

    a_branch_arms: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !cfg_wr && cmd == CMD_BRANCH) |=> armed_reg)
        else $error("taken branch did not arm delay slot");

    a_exc_vector: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !cfg_wr && cmd == CMD_EXC) |=>
            (pc_reg == VEC_ROM || pc_reg == VEC_RAM))
        else $error("exception did not jump to a vector");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import cpuexc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    typedef enum logic [1:0] {
        PHASE_IDLE  = 2'd0,
        PHASE_ARMED = 2'd1,
        PHASE_DELAY = 2'd2
    } slot_phase_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  cmd;
    logic        irq;
    logic [31:0] target;
    logic [4:0]  load_dest;
    logic [31:0] load_data;
    logic [4:0]  exc_code;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] fetch_addr;
    logic        exc_taken;
    logic [31:0] epc_value;
    logic [31:0] cause_value;
    logic [5:0]  mode_bits;
    logic        wb_en;
    logic [4:0]  wb_reg;
    logic [31:0] wb_value;
    logic [31:0] pc_after;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [31:0] cfg_data;

    // sequencer model state
    logic        bev_sel;
    logic [31:0] start_addr;
    logic [31:0] pc_q;
    logic [31:0] npc_q;
    logic [31:0] ipc_q;
    slot_phase_t phase_q;
    logic [31:0] branch_dest_q;
    logic [4:0]  pend_reg_q;
    logic [31:0] pend_val_q;
    logic [4:0]  retire_reg_q;
    logic [31:0] retire_val_q;
    logic [5:0]  mode_q;
    logic [31:0] epc_q;
    logic [31:0] cause_q;

    res_t pending_results[$];
    int   errors = 0;
    int   cycles = 0;
    bit   gaps_on = 1'b1;
    int   stall_left = 0;
    logic [4:0] last_dest = 5'd0;

    cpu_exception_and_delay_slot_control DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .irq         (irq),
        .target      (target),
        .load_dest   (load_dest),
        .load_data   (load_data),
        .exc_code    (exc_code),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .fetch_addr  (fetch_addr),
        .exc_taken   (exc_taken),
        .epc_value   (epc_value),
        .cause_value (cause_value),
        .mode_bits   (mode_bits),
        .wb_en       (wb_en),
        .wb_reg      (wb_reg),
        .wb_value    (wb_value),
        .pc_after    (pc_after),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic void load_start(logic [31:0] addr);
        pc_q  = addr;
        npc_q = addr + INSTR_BYTES;
        ipc_q = addr;
    endfunction

    function automatic void reset_model();
        bev_sel       = 1'b1;
        start_addr    = START_RESET;
        load_start(start_addr);
        phase_q       = PHASE_IDLE;
        branch_dest_q = '0;
        pend_reg_q    = '0;
        pend_val_q    = '0;
        retire_reg_q  = '0;
        retire_val_q  = '0;
        mode_q        = '0;
        epc_q         = '0;
        cause_q       = '0;
    endfunction

    function automatic void enter_exception(logic [4:0] code, logic from_irq);
        logic [31:0] saved;
        logic [31:0] bd;
        saved  = from_irq ? pc_q : ipc_q;
        bd     = '0;
        mode_q = {mode_q[3:0], 2'b00};
        if (phase_q == PHASE_DELAY)
        begin
            saved = saved - INSTR_BYTES;
            bd    = 32'h8000_0000;
        end
        epc_q   = saved;
        cause_q = bd | {25'd0, code, 2'b00};
        phase_q = PHASE_IDLE;
        pc_q    = bev_sel ? VEC_ROM : VEC_RAM;
        npc_q   = pc_q + INSTR_BYTES;
    endfunction

    function automatic res_t step_sequencer(logic [2:0] op, logic intr, logic [31:0] dest,
                                            logic [4:0] ldst, logic [31:0] ldat,
                                            logic [4:0] code);
        res_t r;
        r = '0;
        if (phase_q == PHASE_ARMED)
            phase_q = PHASE_DELAY;
        if (intr)
        begin
            enter_exception(5'd0, 1'b1);
            r.exc_taken = 1'b1;
        end
        r.fetch_addr = pc_q;
        pc_q  = npc_q;
        npc_q = npc_q + INSTR_BYTES;
        case (op)
            CMD_BRANCH:
            begin
                phase_q       = PHASE_ARMED;
                branch_dest_q = dest;
            end
            CMD_LOAD:
            begin
                pend_reg_q = ldst;
                pend_val_q = ldat;
            end
            CMD_EXC:
            begin
                enter_exception(code, 1'b0);
                r.exc_taken = 1'b1;
            end
            CMD_RFE:
                mode_q = {mode_q[5:4], mode_q[5:2]};
            default: ;
        endcase
        // retiring load is dropped when overtaken by a load to the same register
        if (pend_reg_q != retire_reg_q && retire_reg_q != 5'd0)
        begin
            r.wb_en    = 1'b1;
            r.wb_reg   = retire_reg_q;
            r.wb_value = retire_val_q;
        end
        retire_reg_q = pend_reg_q;
        retire_val_q = pend_val_q;
        pend_reg_q   = 5'd0;
        if (phase_q == PHASE_DELAY)
        begin
            pc_q    = branch_dest_q;
            npc_q   = branch_dest_q + INSTR_BYTES;
            phase_q = PHASE_IDLE;
        end
        ipc_q = pc_q;
        r.epc_value   = epc_q;
        r.cause_value = cause_q;
        r.mode_bits   = mode_q;
        r.pc_after    = pc_q;
        return r;
    endfunction

    task automatic send_instr(logic [2:0] op, logic intr, logic [31:0] dest,
                              logic [4:0] ldst, logic [31:0] ldat, logic [4:0] code);
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        cmd       <= op;
        irq       <= intr;
        target    <= dest;
        load_dest <= ldst;
        load_data <= ldat;
        exc_code  <= code;
        do
            @(posedge clk);
        while (in_stall);
        pending_results.push_back(step_sequencer(op, intr, dest, ldst, ldat, code));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_BEV)
            bev_sel = value[0];
        else
        begin
            start_addr = value;
            load_start(start_addr);
        end
        @(posedge clk);
    endtask

    task automatic random_instr();
        int          pick;
        logic [2:0]  op;
        logic [4:0]  ldst;
        pick = $urandom_range(0, 99);
        if (pick < 35)      op = CMD_PLAIN;
        else if (pick < 55) op = CMD_BRANCH;
        else if (pick < 78) op = CMD_LOAD;
        else if (pick < 87) op = CMD_EXC;
        else if (pick < 96) op = CMD_RFE;
        else                op = 3'($urandom_range(5, 7));
        // reuse the last destination now and then so loads overtake each other
        ldst = ($urandom_range(0, 3) == 0) ? last_dest : 5'($urandom_range(0, 31));
        if (op == CMD_LOAD)
            last_dest = ldst;
        send_instr(op, $urandom_range(0, 15) == 0, $urandom, ldst, $urandom,
                   5'($urandom_range(0, 31)));
    endtask

    task automatic test_directed();
        send_instr(CMD_PLAIN,  1'b0, 32'h0,         5'd0,  32'h0,         5'd0);
        send_instr(CMD_BRANCH, 1'b0, 32'hFFFF_FFFF, 5'd0,  32'h0,         5'd0);
        send_instr(CMD_PLAIN,  1'b0, 32'h0,         5'd0,  32'h0,         5'd0);
        send_instr(CMD_BRANCH, 1'b0, 32'h0,         5'd0,  32'h0,         5'd0);
        // exception raised in the delay slot
        send_instr(CMD_EXC,    1'b0, 32'h0,         5'd0,  32'h0,         5'd31);
        send_instr(CMD_RFE,    1'b0, 32'h0,         5'd0,  32'h0,         5'd0);
        send_instr(CMD_LOAD,   1'b0, 32'h0,         5'd31, 32'hFFFF_FFFF, 5'd0);
        send_instr(CMD_LOAD,   1'b0, 32'h0,         5'd31, 32'h0,         5'd0);
        send_instr(CMD_LOAD,   1'b0, 32'h0,         5'd0,  32'hFFFF_FFFF, 5'd0);
        send_instr(CMD_PLAIN,  1'b0, 32'h0,         5'd0,  32'h0,         5'd0);
        send_instr(CMD_LOAD,   1'b0, 32'h0,         5'd1,  32'h5A5A_A5A5, 5'd0);
        send_instr(CMD_PLAIN,  1'b0, 32'h0,         5'd0,  32'h0,         5'd0);
        send_instr(CMD_PLAIN,  1'b1, 32'h0,         5'd0,  32'h0,         5'd0);
        send_instr(CMD_BRANCH, 1'b0, 32'h1234_5678, 5'd0,  32'h0,         5'd0);
        // interrupt arriving in the delay slot
        send_instr(CMD_PLAIN,  1'b1, 32'h0,         5'd0,  32'h0,         5'd0);
        send_instr(CMD_EXC,    1'b1, 32'h0,         5'd0,  32'h0,         5'd0);
        send_instr(CMD_RFE,    1'b0, 32'h0,         5'd0,  32'h0,         5'd0);
        send_instr(CMD_RFE,    1'b0, 32'h0,         5'd0,  32'h0,         5'd0);
        send_instr(3'd5,       1'b0, 32'hFFFF_FFFF, 5'd31, 32'hFFFF_FFFF, 5'd31);
        send_instr(3'd6,       1'b0, 32'hA5A5_5A5A, 5'd10, 32'h1357_9BDF, 5'd21);
        send_instr(3'd7,       1'b0, 32'h0,         5'd5,  32'h0,         5'd10);
        send_instr(CMD_EXC,    1'b0, 32'h0,         5'd0,  32'h0,         5'd21);
        send_instr(CMD_PLAIN,  1'b0, 32'h0,         5'd0,  32'h0,         5'd0);
        drain();
    endtask

    task automatic test_vectors();
        write_reg(CFG_BEV, 32'd0);
        write_reg(CFG_START, 32'h0);
        send_instr(CMD_PLAIN,  1'b0, 32'h0,         5'd0,  32'h0,         5'd0);
        send_instr(CMD_EXC,    1'b0, 32'h0,         5'd0,  32'h0,         5'd9);
        send_instr(CMD_PLAIN,  1'b1, 32'h0,         5'd0,  32'h0,         5'd0);
        drain();
        // pc wraps past the top of the address space
        write_reg(CFG_START, 32'hFFFF_FFFC);
        send_instr(CMD_PLAIN,  1'b0, 32'h0,         5'd0,  32'h0,         5'd0);
        send_instr(CMD_PLAIN,  1'b0, 32'h0,         5'd0,  32'h0,         5'd0);
        drain();
        write_reg(CFG_BEV, 32'hFFFF_FFFF);
        write_reg(CFG_START, 32'hFFFF_FFFF);
        send_instr(CMD_PLAIN,  1'b1, 32'h0,         5'd0,  32'h0,         5'd0);
        send_instr(CMD_RFE,    1'b0, 32'h0,         5'd0,  32'h0,         5'd0);
        drain();
    endtask

    task automatic test_random();
        logic [31:0] starts [5] = '{32'h0, 32'hFFFF_FFFC, 32'hBFC0_0000, 32'h8000_0000, 32'h0};
        for (int p = 0; p < 5; p++)
        begin
            write_reg(CFG_BEV, 32'(p % 2));
            write_reg(CFG_START, (p == 4) ? $urandom : starts[p]);
            repeat (330) random_instr();
            drain();
        end
    endtask

    task automatic test_back_to_back();
        gaps_on = 1'b0;
        write_reg(CFG_BEV, 32'd1);
        write_reg(CFG_START, START_RESET);
        repeat (300) random_instr();
        drain();
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t %s mismatch: expected %h actual %h", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t unexpected result: expected none actual fetch_addr %h",
                         $time, fetch_addr);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("fetch_addr", want.fetch_addr, fetch_addr);
                check_field("exc_taken", 32'(want.exc_taken), 32'(exc_taken));
                check_field("epc_value", want.epc_value, epc_value);
                check_field("cause_value", want.cause_value, cause_value);
                check_field("mode_bits", 32'(want.mode_bits), 32'(mode_bits));
                check_field("wb_en", 32'(want.wb_en), 32'(wb_en));
                check_field("wb_reg", 32'(want.wb_reg), 32'(wb_reg));
                check_field("wb_value", want.wb_value, wb_value);
                check_field("pc_after", want.pc_after, pc_after);
            end
        end
    end

    // result side backpressure in random bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (gaps_on && $urandom_range(0, 6) == 0)
        begin
            stall_left = $urandom_range(0, 8);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("cpu_exception_and_delay_slot_control test failed");
            $finish;
        end
    end

    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        cmd       <= CMD_PLAIN;
        irq       <= 1'b0;
        target    <= '0;
        load_dest <= '0;
        load_data <= '0;
        exc_code  <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_BEV;
        cfg_data  <= '0;
        reset_model();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_vectors();
        test_random();
        test_back_to_back();
        if (errors == 0)
            $display("cpu_exception_and_delay_slot_control test passed");
        else
            $display("cpu_exception_and_delay_slot_control test failed");
        $finish;
    end

endmodule
